@@ hdl/rhh_pkg.sv @@
// Shared types and constants of the Robin Hood hash table unit.
package rhh_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_DEL   = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [0:0] REG_MISS_VALUE = 1'b0;
  localparam logic [0:0] REG_FILL_LIMIT = 1'b1;

  localparam logic [63:0] HASH_SEED = 64'h100;
  localparam logic [63:0] HASH_MULT = 64'd1111111111111111111;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} front_state_t;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_FRD, B_FCHK, B_FKEY, B_ACT, B_GVAL, B_INS_RD, B_INS_CHK,
    B_DVAL, B_DLK, B_RPT, B_BS_RD, B_BS_CHK, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [31:0] miss_value;
    logic [7:0]  fill_limit;
  } cfg_t;

endpackage

@@ hdl/rhh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rhh_fifo.sv @@
// Two-entry queue between the hashing front end and the table sequencer.
module rhh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             not_full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       used;

  assign not_full  = (used != 2'd2);
  assign not_empty = (used != 2'd0);
  assign rdata     = entry[rptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      entry[wptr] <= wdata;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push && not_full) begin
        wptr <= ~wptr;
      end
      if (pop && not_empty) begin
        rptr <= ~rptr;
      end
      used <= used + 2'((push && not_full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

@@ hdl/rhh_front.sv @@
// Front end: accepts requests and computes the home slot by an iterative hash.
module rhh_front import rhh_pkg::*; #(
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32,
  parameter int AW         = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [63:0]           key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  q_push,
  input  logic                  q_not_full,
  output logic [1:0]            q_op,
  output logic [63:0]           q_key,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [AW-1:0]         q_home
);

  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
  localparam logic [31:0] ML = HASH_MULT[31:0];
  localparam logic [31:0] MH = HASH_MULT[63:32];

  front_state_t          state, state_next;
  logic [1:0]            op_r;
  logic [63:0]           key_r;
  logic [63:0]           sh;
  logic [VALUE_BITS-1:0] val_r;
  logic [63:0]           h;
  logic [3:0]            cnt;
  logic [63:0]           p_ll;
  logic [31:0]           p_x1;
  logic [31:0]           p_x2;
  logic [63:0]           x;

  assign x       = h ^ {56'b0, sh[7:0]};
  assign q_op    = op_r;
  assign q_key   = key_r;
  assign q_value = val_r;
  assign q_home  = h[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_MUL;
        end
      end
      F_MUL: state_next = F_SUM;
      F_SUM: begin
        state_next = (cnt == 4'(KEY_BYTES - 1)) ? F_PUSH : F_MUL;
      end
      F_PUSH: begin
        q_push = 1'b1;
        if (q_not_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Each byte passes through F_MUL and F_SUM: the partial products of the 64-bit multiply,
  // then their sum modulo 2^64.
  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        op_r  <= op;
        key_r <= key & KEY_MASK;
        sh    <= key & KEY_MASK;
        val_r <= value;
        h     <= HASH_SEED;
        cnt   <= 4'd0;
      end
      F_MUL: begin
        p_ll <= 64'(x[31:0]) * 64'(ML);
        p_x1 <= x[63:32] * ML;
        p_x2 <= x[31:0] * MH;
      end
      F_SUM: begin
        h   <= p_ll + {p_x1 + p_x2, 32'b0};
        sh  <= sh >> 8;
        cnt <= cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/rhh_back.sv @@
// Back end: sequences probe, insert, relocate and backshift over the table memories.
module rhh_back import rhh_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32,
  parameter int AW         = 8,
  parameter int CW         = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_not_empty,
  output logic                  q_pop,
  input  logic [1:0]            q_op,
  input  logic [63:0]           q_key,
  input  logic [VALUE_BITS-1:0] q_value,
  input  logic [AW-1:0]         q_home,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            status,
  output logic [VALUE_BITS-1:0] value_res,
  output logic [CW-1:0]         count
);

  back_state_t           state, state_next;
  logic [1:0]            op_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]         home_r;
  logic [63:0]           fkey;
  logic [AW-1:0]         i;
  logic [AW-1:0]         d;
  logic [AW-1:0]         cur_home;
  logic [AW-1:0]         cur_idx;
  logic                  hit;
  logic [AW-1:0]         fslot;
  logic [AW-1:0]         fidx;
  logic                  relocate;
  logic [AW-1:0]         sslot;
  logic [AW-1:0]         pidx;
  logic [AW-1:0]         eh;
  logic [AW-1:0]         ei;
  logic [AW-1:0]         cur;
  logic [63+AW:0]        lkey;
  logic [VALUE_BITS-1:0] lval;
  logic [AW-1:0]         entries;
  logic [2:0]            st_r;
  logic [VALUE_BITS-1:0] res_r;

  logic                  slot_we, key_we, val_we;
  logic [AW-1:0]         slot_wa, key_wa, val_wa, slot_ra, key_ra, val_ra;
  logic [2*AW-1:0]       slot_wd, slot_rd;
  logic [63+AW:0]        key_wd, key_rd;
  logic [VALUE_BITS-1:0] val_wd, val_rd;

  logic [AW-1:0]         sd_home, sd_idx;
  logic [VALUE_BITS-1:0] dflt;
  logic                  full_now;
  logic                  ins_go;

  assign sd_home  = slot_rd[2*AW-1:AW];
  assign sd_idx   = slot_rd[AW-1:0];
  assign dflt     = VALUE_BITS'(cfg.miss_value);
  assign full_now = (16'(entries) >= 16'(cfg.fill_limit)) ||
                    (16'(entries) >= 16'(CAPACITY - 1));
  assign ins_go   = (state == B_ACT) && !relocate && (op_r == OP_PUT) && !hit && !full_now;

  rhh_ram #(.WIDTH(2 * AW), .DEPTH(CAPACITY)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd)
  );
  rhh_ram #(.WIDTH(64 + AW), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd)
  );
  rhh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop   = 1'b0;
    slot_we = 1'b0;
    slot_wa = i;
    slot_wd = {eh, ei};
    slot_ra = i;
    key_we  = 1'b0;
    key_wa  = entries + AW'(1);
    key_wd  = {fkey, home_r};
    key_ra  = cur_idx;
    val_we  = 1'b0;
    val_wa  = entries + AW'(1);
    val_wd  = val_r;
    val_ra  = fidx;
    unique case (state)
      B_CLEAR: begin
        slot_we = 1'b1;
        slot_wd = '0;
        if (i == AW'(CAPACITY - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          state_next = B_FRD;
        end
      end
      B_FRD: state_next = B_FCHK;
      B_FCHK: begin
        key_ra = sd_idx;
        state_next = (sd_idx == '0) ? B_ACT : B_FKEY;
      end
      B_FKEY: begin
        if (key_rd[63+AW:AW] == fkey || AW'(i - cur_home) < d) begin
          state_next = B_ACT;
        end else begin
          state_next = B_FRD;
        end
      end
      B_ACT: begin
        if (relocate) begin
          state_next = B_RPT;
        end else if (op_r == OP_PUT) begin
          if (hit) begin
            val_we = 1'b1;
            val_wa = fidx;
            state_next = B_DONE;
          end else if (full_now) begin
            state_next = B_DONE;
          end else begin
            key_we = 1'b1;
            val_we = 1'b1;
            state_next = B_INS_RD;
          end
        end else if (op_r == OP_DEL) begin
          state_next = hit ? B_DVAL : B_DONE;
        end else begin
          state_next = hit ? B_GVAL : B_DONE;
        end
      end
      B_GVAL: state_next = B_DONE;
      B_INS_RD: state_next = B_INS_CHK;
      B_INS_CHK: begin
        if (sd_idx == '0) begin
          slot_we = 1'b1;
          state_next = B_DONE;
        end else begin
          slot_we = (AW'(i - sd_home) < d);
          state_next = B_INS_RD;
        end
      end
      B_DVAL: begin
        key_ra = entries;
        val_ra = entries;
        state_next = (entries != fidx) ? B_DLK : B_BS_RD;
      end
      B_DLK: state_next = B_FRD;
      B_RPT: begin
        // Point the last pair's slot at the freed pair entry and move the pair there.
        slot_we = hit;
        slot_wa = fslot;
        slot_wd = {cur_home, pidx};
        key_we  = 1'b1;
        key_wa  = pidx;
        key_wd  = lkey;
        val_we  = 1'b1;
        val_wa  = pidx;
        val_wd  = lval;
        state_next = B_BS_RD;
      end
      B_BS_RD: begin
        slot_ra = cur + AW'(1);
        state_next = B_BS_CHK;
      end
      B_BS_CHK: begin
        slot_we = 1'b1;
        slot_wa = cur;
        if (sd_idx == '0 || sd_home == AW'(cur + AW'(1))) begin
          slot_wd = '0;
          state_next = B_DONE;
        end else begin
          slot_wd = slot_rd;
          state_next = B_BS_RD;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      entries   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: i <= i + AW'(1);
        B_IDLE: begin
          op_r     <= q_op;
          val_r    <= q_value;
          home_r   <= q_home;
          fkey     <= q_key;
          i        <= q_home;
          d        <= '0;
          relocate <= 1'b0;
          hit      <= 1'b0;
        end
        B_FCHK: begin
          cur_home <= sd_home;
          cur_idx  <= sd_idx;
          hit      <= 1'b0;
        end
        B_FKEY: begin
          if (key_rd[63+AW:AW] == fkey) begin
            hit   <= 1'b1;
            fslot <= i;
            fidx  <= cur_idx;
          end else begin
            i <= i + AW'(1);
            d <= d + AW'(1);
          end
        end
        B_ACT: begin
          if (!relocate) begin
            if (op_r == OP_PUT) begin
              if (hit) begin
                st_r  <= ST_UPDATED;
                res_r <= val_r;
              end else if (full_now) begin
                st_r  <= ST_FULL;
                res_r <= dflt;
              end else begin
                st_r    <= ST_INSERTED;
                res_r   <= val_r;
                entries <= entries + AW'(1);
                eh      <= home_r;
                ei      <= entries + AW'(1);
                i       <= home_r;
                d       <= '0;
              end
            end else begin
              st_r  <= ST_NOTFOUND;
              res_r <= dflt;
            end
          end
        end
        B_GVAL: begin
          st_r  <= ST_FOUND;
          res_r <= val_rd;
        end
        B_INS_CHK: begin
          if (sd_idx != '0) begin
            if (AW'(i - sd_home) < d) begin
              eh <= sd_home;
              ei <= sd_idx;
              d  <= AW'(i - sd_home) + AW'(1);
            end else begin
              d <= d + AW'(1);
            end
            i <= i + AW'(1);
          end
        end
        B_DVAL: begin
          st_r  <= ST_DELETED;
          res_r <= val_rd;
          sslot <= fslot;
          pidx  <= fidx;
          cur   <= fslot;
          if (entries == fidx) begin
            entries <= entries - AW'(1);
          end
        end
        B_DLK: begin
          lkey     <= key_rd;
          lval     <= val_rd;
          fkey     <= key_rd[63+AW:AW];
          i        <= key_rd[AW-1:0];
          d        <= '0;
          relocate <= 1'b1;
        end
        B_RPT: begin
          entries <= entries - AW'(1);
          cur     <= sslot;
        end
        B_BS_CHK: begin
          cur <= cur + AW'(1);
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            status    <= st_r;
            value_res <= res_r;
            count     <= CW'(entries);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    16'(entries) <= 16'(CAPACITY - 1))
    else $error("pair count exceeds table capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_go |=> entries == AW'($past(entries) + AW'(1)))
    else $error("insert did not advance the pair count");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == B_IDLE) && q_not_empty)
    else $error("queue popped outside idle or while empty");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == B_CLEAR)
    else $error("clearing pass skipped after reset");

endmodule

@@ hdl/robin_hood_hash_table_unit.sv @@
// Top level of the Robin Hood hash table unit: configuration registers and wiring.
// Usage: requests (op, key, value) arrive on the in_valid/in_ready channel; each accepted
// beat yields exactly one result beat (status, value_res, count) on out_valid/out_ready.
// op 0 puts, 1 gets, 2 deletes; op 3 behaves as a get.
// The front end takes a beat only when idle, hashes the key byte by byte, each byte in
// F_MUL and F_SUM (the partial products of one 64-bit multiply, then their sum), and
// then hands the request to a two-entry queue, waiting in F_PUSH while the queue is
// full; it takes no new beat until the last one is queued. The back end probes each
// occupied slot in B_FRD, B_FCHK and B_FKEY. An insert then walks the slots from the
// home slot to the first empty one; a delete adds a probe for the last pair, unless
// it deleted that pair, and backshifts the slots that follow. Long probe walks make
// the back end, not the front end, set the rate. After reset the back end clears the
// slot memory, one entry a cycle, before it serves requests; requests are still taken
// into the queue. A stalled receiver holds the result in the output register; the back
// end waits with its next result, and the queue then fills and in_ready falls. cfg_we
// writes cfg_data to register cfg_index (0 default value, 1 fill limit); the user must
// write only while idle, which the block itself does not enforce. CAPACITY must be a
// power of two.
module robin_hood_hash_table_unit import rhh_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [63:0]                    key,
  input  logic [VALUE_BITS-1:0]          value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [VALUE_BITS-1:0]          value_res,
  output logic [$clog2(CAPACITY+1)-1:0]  count,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int QW = 2 + 64 + VALUE_BITS + AW;

  cfg_t                  cfg;
  logic                  q_push, q_not_full, q_pop, q_not_empty;
  logic [1:0]            f_op;
  logic [63:0]           f_key;
  logic [VALUE_BITS-1:0] f_value;
  logic [AW-1:0]         f_home;
  logic [QW-1:0]         q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.miss_value <= 32'd0;
      cfg.fill_limit <= 8'd179;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MISS_VALUE: cfg.miss_value <= cfg_data;
        REG_FILL_LIMIT: cfg.fill_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rhh_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .key(key), .value(value),
    .q_push(q_push), .q_not_full(q_not_full),
    .q_op(f_op), .q_key(f_key), .q_value(f_value), .q_home(f_home)
  );

  rhh_fifo #(.WIDTH(QW)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .not_full(q_not_full),
    .wdata({f_op, f_key, f_value, f_home}),
    .pop(q_pop), .not_empty(q_not_empty), .rdata(q_rdata)
  );

  rhh_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .AW(AW), .CW(CW)) u_back (
    .clk(clk), .rst(rst), .q_not_empty(q_not_empty), .q_pop(q_pop),
    .q_op(q_rdata[QW-1:QW-2]),
    .q_key(q_rdata[QW-3:VALUE_BITS+AW]),
    .q_value(q_rdata[VALUE_BITS+AW-1:AW]),
    .q_home(q_rdata[AW-1:0]),
    .cfg(cfg),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .value_res(value_res), .count(count)
  );

endmodule
